>>> hw/rtl/sppid_pkg.sv
package sppid_pkg;

   localparam int FRACTION_BITS  = 12;
   localparam int STEP_LIMIT     = 400;
   localparam int HOME_TOLERANCE = 500;

   localparam int GAIN_W     = 16;
   localparam int SPR_W      = 18;
   localparam int HOFF_W     = 18;
   localparam int POS_W      = 32;
   localparam int DIFF_W     = POS_W + 1;
   localparam int OUTSTEP_W  = 10;
   localparam int SPEED_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam int MUL_A_W = 49;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 56;
   localparam int DTERM_W = 48;
   localparam int INT_W   = GAIN_W + FRACTION_BITS + 2;
   localparam int MAG_W   = ACC_W - FRACTION_BITS;

   localparam int LPF_A = ((2846 << FRACTION_BITS) + 5000) / 10000;
   localparam int LPF_B = (1 << FRACTION_BITS) - LPF_A;
   localparam int HALF  = 1 << (FRACTION_BITS - 1);

   localparam int DIV_N = DIFF_W;
   localparam int CNT_W = $clog2(DIV_N + 1);

   localparam int PROG_LEN = 18;
   localparam int PC_W     = $clog2(PROG_LEN);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP,
      REG_KI,
      REG_KD,
      REG_ILIM,
      REG_SMAX,
      REG_SMIN,
      REG_SPR,
      REG_HOFF
   } reg_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_HOME,
      OP_ERR,
      OP_DIV,
      OP_REM,
      OP_MUL_KI,
      OP_INT,
      OP_MUL_BKD,
      OP_DGAIN,
      OP_DPOS,
      OP_MUL_AD,
      OP_RND,
      OP_MUL_DDP,
      OP_DSUB,
      OP_MUL_KP,
      OP_SUM,
      OP_MAG,
      OP_SAT,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_SPR_ZERO,
      COND_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            last;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } ctrl_type;

   typedef struct packed {
      logic spr_zero;
      logic div_more;
      logic out_stall;
   } status_type;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_NOP, cond: COND_NEXT, target: '0, last: 1'b1};
      unique case (pc)
         5'd0: w = '{op: OP_HOME, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd1: w = '{op: OP_ERR, cond: COND_SPR_ZERO, target: 5'd4, last: 1'b0};
         5'd2: w = '{op: OP_DIV, cond: COND_DIV_MORE, target: 5'd2, last: 1'b0};
         5'd3: w = '{op: OP_REM, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd4: w = '{op: OP_MUL_KI, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd5: w = '{op: OP_INT, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd6: w = '{op: OP_MUL_BKD, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd7: w = '{op: OP_DGAIN, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd8: w = '{op: OP_DPOS, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd9: w = '{op: OP_MUL_AD, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd10: w = '{op: OP_RND, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd11: w = '{op: OP_MUL_DDP, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd12: w = '{op: OP_DSUB, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd13: w = '{op: OP_MUL_KP, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd14: w = '{op: OP_SUM, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd15: w = '{op: OP_MAG, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd16: w = '{op: OP_SAT, cond: COND_NEXT, target: '0, last: 1'b0};
         5'd17: w = '{op: OP_OUT, cond: COND_NEXT, target: '0, last: 1'b1};
         default: w = '{op: OP_NOP, cond: COND_NEXT, target: '0, last: 1'b1};
      endcase
      return w;
   endfunction

   // Round to nearest with ties away from zero, then drop the fraction.
   function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] bias;
      bias = x[PROD_W-1] ? $signed(PROD_W'(HALF - 1)) : $signed(PROD_W'(HALF));
      return (x + bias) >>> FRACTION_BITS;
   endfunction

endpackage

>>> hw/rtl/sppid_if.sv
interface sppid_req_if import sppid_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] set_point;
   logic signed [POS_W-1:0] current_count;
   logic                    home_pressed;

   modport source (output valid, output set_point, output current_count,
                   output home_pressed, input ready);
   modport sink (input valid, input set_point, input current_count,
                 input home_pressed, output ready);
endinterface

interface sppid_rsp_if import sppid_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUTSTEP_W-1:0] step_request;
   logic [SPEED_W-1:0]          speed_request;
   logic                        run_command;
   logic                        counter_corrected;

   modport source (output valid, output step_request, output speed_request,
                   output run_command, output counter_corrected, input ready);
   modport sink (input valid, input step_request, input speed_request,
                 input run_command, input counter_corrected, output ready);
endinterface

>>> hw/rtl/sppid_seq.sv
module sppid_seq import sppid_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            busy_ff;
   logic            busy_in;
   uword_type       uword;
   logic            jump;
   logic            hold;

   assign uword = ucode_rom(pc_ff);

   always_comb begin
      unique case (uword.cond)
         COND_SPR_ZERO: jump = status.spr_zero;
         COND_DIV_MORE: jump = status.div_more;
         default:       jump = 1'b0;
      endcase
   end

   assign hold = (uword.op == OP_OUT) && status.out_stall;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (busy_ff && !hold) begin
         if (uword.last) begin
            busy_in = 1'b0;
         end else if (jump) begin
            pc_in = uword.target;
         end else begin
            pc_in = PC_W'(pc_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign ctrl.op   = busy_ff ? uword.op : OP_NOP;
   assign ctrl.load = start;
   assign busy      = busy_ff;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff < PC_W'(PROG_LEN))
      else $error("Step counter ran past the end of the program.");

   a_start_at_entry: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && pc_ff == '0)
      else $error("A new transaction did not start at the first step.");

endmodule

>>> hw/rtl/sppid_dp.sv
module sppid_dp import sppid_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_type                    ctrl,
   output status_type                  status,
   input  logic signed [POS_W-1:0]     set_point,
   input  logic signed [POS_W-1:0]     current_count,
   input  logic                        home_pressed,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [OUTSTEP_W-1:0] step_request,
   output logic [SPEED_W-1:0]          speed_request,
   output logic                        run_command,
   output logic                        counter_corrected
);

   localparam logic signed [ACC_W-1:0] D_MAX = ACC_W'((64'sd1 <<< (DTERM_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] D_MIN = -D_MAX - ACC_W'(1);

   logic [GAIN_W-1:0]        kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [GAIN_W-1:0]        ilim_ff, ilim_in, smax_ff, smax_in, smin_ff, smin_in;
   logic [SPR_W-1:0]         spr_ff, spr_in;
   logic signed [HOFF_W-1:0] hoff_ff, hoff_in;

   logic signed [INT_W-1:0]   integral_ff, integral_in;
   logic signed [DTERM_W-1:0] dterm_ff, dterm_in;
   logic signed [POS_W-1:0]   prev_ff, prev_in;
   logic                      out_valid_ff, out_valid_in;

   logic signed [POS_W-1:0]     sp_ff, sp_in, pos_ff, pos_in;
   logic                        home_ff, home_in, corr_ff, corr_in;
   logic signed [DIFF_W-1:0]    err_ff, err_in, dpos_ff, dpos_in;
   logic                        neg_ff, neg_in;
   logic [DIFF_W-1:0]           quo_ff, quo_in;
   logic [SPR_W-1:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]            div_cnt_ff, div_cnt_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [MUL_B_W-1:0]   dgain_ff, dgain_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [MAG_W-1:0]            mag_ff, mag_in;
   logic [SPEED_W-1:0]          speed_ff, speed_in;
   logic signed [OUTSTEP_W-1:0] rel_ff, rel_in;
   logic signed [OUTSTEP_W-1:0] out_step_ff, out_step_in;
   logic [SPEED_W-1:0]          out_speed_ff, out_speed_in;
   logic                        out_run_ff, out_run_in;
   logic                        out_corr_ff, out_corr_in;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [DIFF_W-1:0]    hdiff, diff;
   logic [DIFF_W-1:0]           hmag, dmag;
   logic [SPR_W:0]              trial;
   logic signed [ACC_W-1:0]     int_sum, lim_pos, lim_neg, dsub;
   logic [ACC_W-1:0]            acc_abs;
   logic                        slow;
   logic [OUTSTEP_W-1:0]        relmag;
   logic signed [OUTSTEP_W-1:0] rel_slow, fin_step;
   logic [SPEED_W-1:0]          fin_speed;
   logic                        out_load;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         OP_MUL_KI: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(ki_ff));
         end
         OP_MUL_BKD: begin
            mul_a = $signed(MUL_A_W'(kd_ff));
            mul_b = $signed(MUL_B_W'(LPF_B));
         end
         OP_MUL_AD: begin
            mul_a = MUL_A_W'(dterm_ff);
            mul_b = $signed(MUL_B_W'(LPF_A));
         end
         OP_MUL_DDP: begin
            mul_a = MUL_A_W'(dpos_ff);
            mul_b = dgain_ff;
         end
         OP_MUL_KP: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(kp_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign hdiff   = DIFF_W'(pos_ff) - DIFF_W'(hoff_ff);
   assign hmag    = hdiff[DIFF_W-1] ? DIFF_W'(-hdiff) : DIFF_W'(hdiff);
   assign diff    = DIFF_W'(sp_ff) - DIFF_W'(pos_ff);
   assign dmag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign trial   = {rem_ff, quo_ff[DIFF_W-1]};
   assign int_sum = ACC_W'(integral_ff) + ACC_W'(prod_ff);
   assign lim_pos = $signed(ACC_W'(ilim_ff) << FRACTION_BITS);
   assign lim_neg = -lim_pos;
   assign dsub    = acc_ff - ACC_W'(prod_ff);
   assign acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   assign slow      = speed_ff < smin_ff;
   assign relmag    = (speed_ff > SPEED_W'(STEP_LIMIT)) ? OUTSTEP_W'(STEP_LIMIT)
                                                        : OUTSTEP_W'(speed_ff);
   assign rel_slow  = rel_ff[OUTSTEP_W-1] ? -$signed(relmag) : $signed(relmag);
   assign fin_step  = slow ? rel_slow : rel_ff;
   assign fin_speed = slow ? smin_ff : speed_ff;

   assign status.spr_zero  = (spr_ff == '0);
   assign status.div_more  = (div_cnt_ff != CNT_W'(1));
   assign status.out_stall = out_valid_ff && !rsp_ready;
   assign out_load         = (ctrl.op == OP_OUT) && !status.out_stall;

   always_comb begin
      kp_in   = kp_ff;
      ki_in   = ki_ff;
      kd_in   = kd_ff;
      ilim_in = ilim_ff;
      smax_in = smax_ff;
      smin_in = smin_ff;
      spr_in  = spr_ff;
      hoff_in = hoff_ff;
      if (csr_write) begin
         unique case (reg_type'(csr_index))
            REG_KP:   kp_in   = csr_data[GAIN_W-1:0];
            REG_KI:   ki_in   = csr_data[GAIN_W-1:0];
            REG_KD:   kd_in   = csr_data[GAIN_W-1:0];
            REG_ILIM: ilim_in = csr_data[GAIN_W-1:0];
            REG_SMAX: smax_in = csr_data[GAIN_W-1:0];
            REG_SMIN: smin_in = csr_data[GAIN_W-1:0];
            REG_SPR:  spr_in  = csr_data[SPR_W-1:0];
            REG_HOFF: hoff_in = $signed(csr_data[HOFF_W-1:0]);
            default:  kp_in   = kp_ff;
         endcase
      end
   end

   always_comb begin
      integral_in  = integral_ff;
      dterm_in     = dterm_ff;
      prev_in      = prev_ff;
      sp_in        = sp_ff;
      pos_in       = pos_ff;
      home_in      = home_ff;
      corr_in      = corr_ff;
      err_in       = err_ff;
      dpos_in      = dpos_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      prod_in      = prod_ff;
      dgain_in     = dgain_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      speed_in     = speed_ff;
      rel_in       = rel_ff;
      out_step_in  = out_step_ff;
      out_speed_in = out_speed_ff;
      out_run_in   = out_run_ff;
      out_corr_in  = out_corr_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (ctrl.load) begin
         sp_in   = set_point;
         pos_in  = current_count;
         home_in = home_pressed;
         corr_in = 1'b0;
      end

      unique case (ctrl.op)
         OP_HOME: begin
            if (home_ff && hmag > DIFF_W'(HOME_TOLERANCE)) begin
               pos_in  = POS_W'(hoff_ff);
               corr_in = 1'b1;
            end
         end
         OP_ERR: begin
            err_in     = diff;
            neg_in     = diff[DIFF_W-1];
            quo_in     = dmag;
            rem_in     = '0;
            div_cnt_in = CNT_W'(DIV_N);
         end
         OP_DIV: begin
            if (trial >= {1'b0, spr_ff}) begin
               rem_in = SPR_W'(trial - {1'b0, spr_ff});
            end else begin
               rem_in = SPR_W'(trial);
            end
            quo_in     = {quo_ff[DIFF_W-2:0], 1'b0};
            div_cnt_in = CNT_W'(div_cnt_ff - 1'b1);
         end
         OP_REM: begin
            err_in = neg_ff ? -$signed(DIFF_W'(rem_ff)) : $signed(DIFF_W'(rem_ff));
         end
         OP_MUL_KI, OP_MUL_BKD, OP_MUL_AD, OP_MUL_DDP, OP_MUL_KP: begin
            prod_in = mul_a * mul_b;
         end
         OP_INT: begin
            if (int_sum > lim_pos) begin
               integral_in = INT_W'(lim_pos);
            end else if (int_sum < lim_neg) begin
               integral_in = INT_W'(lim_neg);
            end else begin
               integral_in = INT_W'(int_sum);
            end
         end
         OP_DGAIN: begin
            dgain_in = MUL_B_W'(rnd_shift(prod_ff));
         end
         OP_DPOS: begin
            dpos_in = DIFF_W'(pos_ff) - DIFF_W'(prev_ff);
            prev_in = pos_ff;
         end
         OP_RND: begin
            acc_in = ACC_W'(rnd_shift(prod_ff));
         end
         OP_DSUB: begin
            if (dsub > D_MAX) begin
               dterm_in = DTERM_W'(D_MAX);
            end else if (dsub < D_MIN) begin
               dterm_in = DTERM_W'(D_MIN);
            end else begin
               dterm_in = DTERM_W'(dsub);
            end
         end
         OP_SUM: begin
            acc_in = ACC_W'(prod_ff) + ACC_W'(integral_ff) + ACC_W'(dterm_ff);
         end
         OP_MAG: begin
            mag_in = MAG_W'(acc_abs >> FRACTION_BITS);
            if (err_ff > DIFF_W'(STEP_LIMIT)) begin
               rel_in = OUTSTEP_W'(STEP_LIMIT);
            end else if (err_ff < -DIFF_W'(STEP_LIMIT)) begin
               rel_in = -OUTSTEP_W'(STEP_LIMIT);
            end else begin
               rel_in = OUTSTEP_W'(err_ff);
            end
         end
         OP_SAT: begin
            speed_in = (mag_ff > MAG_W'(smax_ff)) ? smax_ff : SPEED_W'(mag_ff);
         end
         OP_OUT: begin
            if (out_load) begin
               out_step_in  = fin_step;
               out_speed_in = fin_speed;
               out_run_in   = (fin_speed != '0) && (fin_step != '0);
               out_corr_in  = corr_ff;
               out_valid_in = 1'b1;
            end
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= GAIN_W'(8192);
         ki_ff        <= GAIN_W'(2867);
         kd_ff        <= GAIN_W'(8192);
         ilim_ff      <= GAIN_W'(1000);
         smax_ff      <= GAIN_W'(10000);
         smin_ff      <= GAIN_W'(100);
         spr_ff       <= SPR_W'(14000);
         hoff_ff      <= HOFF_W'(-3000);
         integral_ff  <= '0;
         dterm_ff     <= '0;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         ilim_ff      <= ilim_in;
         smax_ff      <= smax_in;
         smin_ff      <= smin_in;
         spr_ff       <= spr_in;
         hoff_ff      <= hoff_in;
         integral_ff  <= integral_in;
         dterm_ff     <= dterm_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff        <= sp_in;
      pos_ff       <= pos_in;
      home_ff      <= home_in;
      corr_ff      <= corr_in;
      err_ff       <= err_in;
      dpos_ff      <= dpos_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      prod_ff      <= prod_in;
      dgain_ff     <= dgain_in;
      acc_ff       <= acc_in;
      mag_ff       <= mag_in;
      speed_ff     <= speed_in;
      rel_ff       <= rel_in;
      out_step_ff  <= out_step_in;
      out_speed_ff <= out_speed_in;
      out_run_ff   <= out_run_in;
      out_corr_ff  <= out_corr_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign step_request      = out_step_ff;
   assign speed_request     = out_speed_ff;
   assign run_command       = out_run_ff;
   assign counter_corrected = out_corr_ff;

   a_div_count_live: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV) |-> div_cnt_ff != '0)
      else $error("Remainder step ran with an exhausted iteration count.");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_step_ff <= OUTSTEP_W'(STEP_LIMIT))
                    && (out_step_ff >= -OUTSTEP_W'(STEP_LIMIT)))
      else $error("Step request outside the step limit.");

   a_run_consistent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_run_ff == ((out_speed_ff != '0) && (out_step_ff != '0)))
      else $error("Run command disagrees with speed and step request.");

endmodule

>>> hw/rtl/servo_position_pid_step_core.sv
// Position PID step for one servo axis. Each transaction carries a set point, the
// motor's step counter and the home-sensor flag, and yields one result: a step
// request clamped to +-400, a commanded speed, a run flag and a flag telling the
// host to overwrite its counter with the home offset. The loop state (integral,
// filtered derivative on measurement, previous position) lives in the block and
// carries over between transactions. A transaction runs the microcode program
// through the single shared multiplier, and takes the remainder on the position
// error in 33 one-bit iterations, skipped when steps_per_rev is zero. A
// finished result waits in the output register while the next transaction is
// taken. The user must write configuration registers only while no transaction
// is in flight; the block itself does not enforce this.
module servo_position_pid_step_core import sppid_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   sppid_req_if.sink            req_chan,
   sppid_rsp_if.source          rsp_chan,
   input logic                  csr_write,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_type   ctrl;
   status_type status;
   logic       busy;
   logic       start;

   assign req_chan.ready = !busy && !reset;
   assign start          = req_chan.valid && req_chan.ready;

   sppid_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   sppid_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .set_point         (req_chan.set_point),
      .current_count     (req_chan.current_count),
      .home_pressed      (req_chan.home_pressed),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .step_request      (rsp_chan.step_request),
      .speed_request     (rsp_chan.speed_request),
      .run_command       (rsp_chan.run_command),
      .counter_corrected (rsp_chan.counter_corrected)
   );

endmodule
